@@ rtl/mpq_pkg.sv @@
// shared types and codes for the max priority queue
package mpq_pkg;

  localparam int DATA_W = 32;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_SERVICE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic do_insert;
    logic do_service;
  } cell_ctrl_t;

endpackage

@@ rtl/mpq_cell.sv @@
// one slot of the sorted chain: holds an entry and trades it with its neighbors
module mpq_cell import mpq_pkg::*; #(
  parameter int PRIO_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cell_ctrl_t                  ctrl,
  input  logic        [PRIO_BITS-1:0] new_prio,
  input  logic signed [DATA_W-1:0]    new_data,
  input  logic                        prev_keep,
  input  logic                        prev_valid,
  input  logic        [PRIO_BITS-1:0] prev_prio,
  input  logic signed [DATA_W-1:0]    prev_data,
  input  logic                        next_valid,
  input  logic        [PRIO_BITS-1:0] next_prio,
  input  logic signed [DATA_W-1:0]    next_data,
  output logic                        keep,
  output logic                        valid,
  output logic        [PRIO_BITS-1:0] prio,
  output logic signed [DATA_W-1:0]    data
);

  logic                        valid_next;
  logic        [PRIO_BITS-1:0] prio_next;
  logic signed [DATA_W-1:0]    data_next;

  // entry stays put when it ranks at or above the new one (fifo among equals)
  assign keep = valid && (prio >= new_prio);

  always_comb begin
    valid_next = valid;
    prio_next  = prio;
    data_next  = data;
    priority if (ctrl.do_service) begin
      valid_next = next_valid;
      prio_next  = next_prio;
      data_next  = next_data;
    end else if (ctrl.do_insert && !keep) begin
      if (prev_keep) begin
        valid_next = 1'b1;
        prio_next  = new_prio;
        data_next  = new_data;
      end else begin
        valid_next = prev_valid;
        prio_next  = prev_prio;
        data_next  = prev_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      prio  <= '0;
    end else begin
      valid <= valid_next;
      prio  <= prio_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ rtl/max_priority_queue_unit.sv @@
// top level of the max priority queue: a sorted chain of entry cells
//
// Command interface: an item is taken at a rising edge where start is high
// and busy is low. func selects insert (priority_req, data) or service, which
// removes the highest-priority entry; among equal priorities the oldest
// entry leaves first. busy is held low: the chain never stalls, so an item
// may be issued at every edge.
// Each item produces one result: done pulses for one cycle, the cycle after
// the item is taken, with status, front_data, front_priority, is_empty and
// entry_count describing the queue after the operation. Throughput is 1
// item per cycle, set by the single compare-and-shift step of each cell
// that moves the whole chain at once.
// An insert into a full queue or a service of an empty one leaves the queue
// unchanged and reports full or empty status. The receiver cannot stall:
// results are valid only in the cycle done is high.
// Reset (rst, synchronous) empties the queue and clears done.
module max_priority_queue_unit import mpq_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic        [PRIO_BITS-1:0] priority_req,
  input  logic signed [DATA_W-1:0]    data,
  output logic                        done,
  output logic        [1:0]           status,
  output logic signed [DATA_W-1:0]    front_data,
  output logic        [PRIO_BITS-1:0] front_priority,
  output logic                        is_empty,
  output logic        [CNT_W-1:0]     entry_count
);

  logic                        cell_keep  [DEPTH];
  logic                        cell_valid [DEPTH];
  logic        [PRIO_BITS-1:0] cell_prio  [DEPTH];
  logic signed [DATA_W-1:0]    cell_data  [DEPTH];

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  status_t          op_status;
  status_t          op_status_next;
  cell_ctrl_t       ctrl;
  logic             accept;
  logic             full;
  logic             empty;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    ctrl           = '0;
    count_next     = count;
    op_status_next = ST_OK;
    if (accept) begin
      unique case (func)
        FUNC_INSERT: begin
          if (full) begin
            op_status_next = ST_FULL;
          end else begin
            ctrl.do_insert = 1'b1;
            count_next     = count + 1'b1;
          end
        end
        FUNC_SERVICE: begin
          if (empty) begin
            op_status_next = ST_EMPTY;
          end else begin
            ctrl.do_service = 1'b1;
            count_next      = count - 1'b1;
          end
        end
        default: op_status_next = ST_OK;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                        p_keep;
    logic                        p_valid;
    logic        [PRIO_BITS-1:0] p_prio;
    logic signed [DATA_W-1:0]    p_data;
    logic                        n_valid;
    logic        [PRIO_BITS-1:0] n_prio;
    logic signed [DATA_W-1:0]    n_data;

    if (i == 0) begin : g_head
      // nothing ahead of the head: a non-keeping head takes the new entry
      assign p_keep  = 1'b1;
      assign p_valid = 1'b0;
      assign p_prio  = '0;
      assign p_data  = '0;
    end else begin : g_body
      assign p_keep  = cell_keep[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_prio  = cell_prio[i-1];
      assign p_data  = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_prio  = '0;
      assign n_data  = '0;
    end else begin : g_inner
      assign n_valid = cell_valid[i+1];
      assign n_prio  = cell_prio[i+1];
      assign n_data  = cell_data[i+1];
    end

    mpq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_prio   (priority_req),
      .new_data   (data),
      .prev_keep  (p_keep),
      .prev_valid (p_valid),
      .prev_prio  (p_prio),
      .prev_data  (p_data),
      .next_valid (n_valid),
      .next_prio  (n_prio),
      .next_data  (n_data),
      .keep       (cell_keep[i]),
      .valid      (cell_valid[i]),
      .prio       (cell_prio[i]),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      done      <= 1'b0;
      op_status <= ST_OK;
    end else begin
      count     <= count_next;
      done      <= accept;
      op_status <= op_status_next;
    end
  end

  // head cell always holds the front entry
  assign status         = op_status;
  assign is_empty       = !cell_valid[0];
  assign front_data     = cell_valid[0] ? cell_data[0] : '0;
  assign front_priority = cell_valid[0] ? cell_prio[0] : '0;
  assign entry_count    = count;

endmodule
